// ----- rtl/core/bfpa_pkg.sv -----
// Shared types, constants and codes for the best-fit partition allocator.
package bfpa_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 32;
  localparam int unsigned SIZE_WIDTH_DEF = 16;
  localparam int unsigned CFG_W          = 6;
  localparam int unsigned IDX_FIELD_W    = 5;
  localparam int unsigned SIZE_FIELD_W   = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [IDX_FIELD_W-1:0]  frame_index;
    logic [SIZE_FIELD_W-1:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic                    granted;
    logic [IDX_FIELD_W-1:0]  chosen_frame;
    logic [SIZE_FIELD_W-1:0] leftover;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic write;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_end;
  } dp_status_t;

endpackage

// ----- rtl/core/bfpa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bfpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bfpa_ctrl.sv -----
// Control state machine for the best-fit partition allocator.
module bfpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bfpa_pkg::dp_status_t status_i,
  output bfpa_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  bfpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfpa_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = status_i.is_alloc ? bfpa_pkg::ST_SCAN : bfpa_pkg::ST_LOAD;
        end
      end
      bfpa_pkg::ST_LOAD: state_d = bfpa_pkg::ST_DONE;
      bfpa_pkg::ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = bfpa_pkg::ST_DONE;
        end
      end
      bfpa_pkg::ST_DONE: state_d = bfpa_pkg::ST_IDLE;
      default:           state_d = bfpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      bfpa_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      bfpa_pkg::ST_LOAD: cmd_o.write = 1'b1;
      bfpa_pkg::ST_SCAN: cmd_o.issue = !status_i.scan_end;
      bfpa_pkg::ST_DONE: begin
        done_o       = 1'b1;
        cmd_o.commit = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not raise busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_issue_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !cmd_o.write && !cmd_o.commit && busy_o)
    else $error("scan read issued outside scan");

endmodule

// ----- rtl/core/bfpa_dp.sv -----
// Datapath: partition table, used bits, scan counter and best-fit tracking.
module bfpa_dp #(
  parameter int unsigned MAX_FRAMES = bfpa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned SIZE_WIDTH = bfpa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfpa_pkg::CFG_W-1:0]  cfg_data_i,
  input  bfpa_pkg::in_item_t          item_i,
  input  bfpa_pkg::ctrl_cmd_t         cmd_i,
  output bfpa_pkg::dp_status_t        status_o,
  output bfpa_pkg::out_item_t         result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIM_W = (CNT_W > bfpa_pkg::CFG_W) ? CNT_W : bfpa_pkg::CFG_W;

  logic [bfpa_pkg::CFG_W-1:0]       cfg_q;
  logic [MAX_FRAMES-1:0]            used_q, used_d;
  logic [CNT_W-1:0]                 cnt_q;
  logic                             pend_q;
  logic                             found_q, found_d;
  logic                             op_q;
  logic [bfpa_pkg::IDX_FIELD_W-1:0] idx_q;
  logic [SIZE_WIDTH-1:0]            req_q;
  logic [IDX_W-1:0]                 pend_idx_q;
  logic [IDX_W-1:0]                 best_idx_q;
  logic [SIZE_WIDTH-1:0]            best_left_q;

  logic [LIM_W-1:0]      cfg_ext, max_ext, limit;
  logic                  load_ok;
  logic [IDX_W-1:0]      load_idx;
  logic [SIZE_WIDTH-1:0] rd_data, cand_left;
  logic                  cand_fits, cand_better, take;

  assign cfg_ext = LIM_W'(cfg_q);
  assign max_ext = LIM_W'(MAX_FRAMES);
  assign limit   = (cfg_ext > max_ext) ? max_ext : cfg_ext;

  assign status_o.is_alloc = (item_i.operation == bfpa_pkg::OP_ALLOC);
  assign status_o.scan_end = (LIM_W'(cnt_q) >= limit);

  assign load_ok  = (32'(idx_q) < MAX_FRAMES);
  assign load_idx = IDX_W'(idx_q);

  bfpa_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (MAX_FRAMES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && load_ok),
    .waddr_i (load_idx),
    .wdata_i (req_q),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign cand_left   = rd_data - req_q;
  assign cand_fits   = pend_q && !used_q[pend_idx_q] && (rd_data >= req_q);
  assign cand_better = !found_q || (cand_left < best_left_q);
  assign take        = cand_fits && cand_better;

  always_comb begin
    used_d = used_q;
    if (cmd_i.write && load_ok) begin
      used_d[load_idx] = 1'b0;
    end
    if (cmd_i.commit && (op_q == bfpa_pkg::OP_ALLOC) && found_q) begin
      used_d[best_idx_q] = 1'b1;
    end
  end

  always_comb begin
    found_d = found_q;
    if (cmd_i.capture) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      used_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      used_q  <= used_d;
      pend_q  <= cmd_i.issue;
      found_q <= found_d;
      if (cmd_i.capture) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= item_i.operation;
      idx_q <= item_i.frame_index;
      req_q <= SIZE_WIDTH'(item_i.block_size);
    end
    if (cmd_i.issue) begin
      pend_idx_q <= cnt_q[IDX_W-1:0];
    end
    if (take) begin
      best_idx_q  <= pend_idx_q;
      best_left_q <= cand_left;
    end
  end

  assign result_o.granted      = (op_q == bfpa_pkg::OP_ALLOC) && found_q;
  assign result_o.chosen_frame = result_o.granted ? bfpa_pkg::IDX_FIELD_W'(best_idx_q) : '0;
  assign result_o.leftover     = result_o.granted ? bfpa_pkg::SIZE_FIELD_W'(best_left_q) : '0;

  a_pend_after_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(cmd_i.issue))
    else $error("compare without a read beat");

  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q |-> !used_q[best_idx_q])
    else $error("granted partition already in use");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_FRAMES)
    else $error("scan counter past table depth");

endmodule

// ----- rtl/core/best_fit_partition_allocator_unit.sv -----
// Top level of the best-fit partition allocator.
//
// Commands enter on req_i when start is high and busy is low. A load beat
// writes one partition size and frees that partition; an allocate beat scans
// the free partitions among the first frame_count (saturated to MAX_FRAMES)
// and grants the one with the smallest leftover, lowest index on a tie.
// Every command returns exactly one result beat on rsp_o, marked by done_o
// for one cycle; the receiver cannot stall, so it must take it then.
// A load passes through the load state and then the result state. An allocate
// reads the size table one partition per cycle through its single read port,
// compares each registered read with the request in the cycle after it, and
// then enters the result state. busy stays high until the result cycle
// ends; one command is in flight at a time.
// frame_count is written on cfg_data_i with cfg_valid_i/cfg_ready_o; ready
// is high while the block is idle.
// Reset clears frame_count and marks all partitions free. Partition sizes are
// undefined until loaded.
module best_fit_partition_allocator_unit #(
  parameter int unsigned MAX_FRAMES = bfpa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned SIZE_WIDTH = bfpa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bfpa_pkg::in_item_t         req_i,
  output logic                       done_o,
  output bfpa_pkg::out_item_t        rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfpa_pkg::CFG_W-1:0] cfg_data_i
);

  bfpa_pkg::ctrl_cmd_t  cmd;
  bfpa_pkg::dp_status_t status;

  assign cfg_ready_o = !busy;

  bfpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  bfpa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .item_i     (req_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (rsp_o)
  );

endmodule

// ----- tb/best_fit_partition_allocator_unit_tb.sv -----
// Self-checking testbench for the best-fit partition allocator: load/allocate beats.
module best_fit_partition_allocator_unit_tb;
  import bfpa_pkg::*;

  class fit_tracker;
    logic [SIZE_FIELD_W-1:0] part_size [MAX_FRAMES_DEF];
    bit                      part_used [MAX_FRAMES_DEF];
    int unsigned             frame_limit;
    out_item_t               pending_grants [$];
    int unsigned             mismatches;

    function new();
      foreach (part_used[j]) begin
        part_used[j] = 1'b0;
        part_size[j] = '0;
      end
      frame_limit = 0;
      mismatches  = 0;
    endfunction

    function void set_frame_count(logic [CFG_W-1:0] value);
      frame_limit = 32'(value);
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void note_command(in_item_t cmd);
      out_item_t               grant;
      int unsigned             lim;
      bit                      found;
      logic [SIZE_FIELD_W-1:0] best_left;
      logic [SIZE_FIELD_W-1:0] slack;
      int unsigned             best_idx;
      grant     = '0;
      found     = 1'b0;
      best_left = '0;
      best_idx  = 0;
      if (cmd.operation == OP_LOAD) begin
        part_size[cmd.frame_index] = cmd.block_size;
        part_used[cmd.frame_index] = 1'b0;
      end else begin
        lim = (frame_limit > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_limit;
        for (int unsigned j = 0; j < lim; j++) begin
          if (!part_used[j] && part_size[j] >= cmd.block_size) begin
            slack = part_size[j] - cmd.block_size;
            if (!found || slack < best_left) begin
              found     = 1'b1;
              best_left = slack;
              best_idx  = j;
            end
          end
        end
        if (found) begin
          part_used[best_idx] = 1'b1;
          grant.granted       = 1'b1;
          grant.chosen_frame  = IDX_FIELD_W'(best_idx);
          grant.leftover      = best_left;
        end
      end
      pending_grants.push_back(grant);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("result beat with no command outstanding: %h", got));
      end else begin
        want = pending_grants.pop_front();
        if (got.granted !== want.granted)
          report_mismatch($sformatf("granted %b, want %b", got.granted, want.granted));
        if (got.chosen_frame !== want.chosen_frame)
          report_mismatch($sformatf("chosen_frame %0d, want %0d",
                                    got.chosen_frame, want.chosen_frame));
        if (got.leftover !== want.leftover)
          report_mismatch($sformatf("leftover %0d, want %0d", got.leftover, want.leftover));
      end
    endtask
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  in_item_t         req_i       = '0;
  logic             done_o;
  out_item_t        rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  fit_tracker                tracker;
  logic [MAX_FRAMES_DEF-1:0] sized_mask = '0;
  logic [CFG_W-1:0]          cur_count  = '0;
  int unsigned               sent       = 0;
  bit                        quiet_phase = 1'b0;

  always #5 clk_i = ~clk_i;

  best_fit_partition_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(rsp_o);
  end

  function automatic int unsigned eff_limit();
    return (cur_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : 32'(cur_count);
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIZE_FIELD_W-1:0] pick_size(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (mode == 0) return SIZE_FIELD_W'($urandom_range(0, 15));
    if (mode == 1) return SIZE_FIELD_W'($urandom_range(0, 255));
    return SIZE_FIELD_W'($urandom);
  endfunction

  task automatic send_cmd(in_item_t cmd);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
    tracker.note_command(cmd);
    if (cmd.operation == OP_LOAD) sized_mask[cmd.frame_index] = 1'b1;
    sent++;
  endtask

  task automatic load_part(int unsigned idx, int unsigned size);
    in_item_t cmd;
    cmd.operation   = OP_LOAD;
    cmd.frame_index = IDX_FIELD_W'(idx);
    cmd.block_size  = SIZE_FIELD_W'(size);
    send_cmd(cmd);
  endtask

  task automatic alloc_req(int unsigned size);
    in_item_t cmd;
    cmd.operation   = OP_ALLOC;
    cmd.frame_index = IDX_FIELD_W'($urandom_range(0, 31));
    cmd.block_size  = SIZE_FIELD_W'(size);
    send_cmd(cmd);
  endtask

  task automatic set_count(logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_frame_count(value);
    cur_count = value;
  endtask

  task automatic random_cmd(int unsigned mode);
    in_item_t    cmd;
    int unsigned lim;
    lim = eff_limit();
    cmd.operation   = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_LOAD;
    cmd.frame_index = (lim != 0 && $urandom_range(0, 3) != 0) ?
                      IDX_FIELD_W'($urandom_range(0, lim - 1)) :
                      IDX_FIELD_W'($urandom_range(0, 31));
    cmd.block_size  = pick_size(mode);
    // load the lowest unsized partition in range instead of scanning it
    if (cmd.operation == OP_ALLOC) begin
      for (int unsigned j = lim; j > 0; j--) begin
        if (!sized_mask[j-1]) begin
          cmd.operation   = OP_LOAD;
          cmd.frame_index = IDX_FIELD_W'(j - 1);
        end
      end
    end
    send_cmd(cmd);
  endtask

  initial begin
    int unsigned      waited;
    int unsigned      phase_len;
    int unsigned      mode;
    logic [CFG_W-1:0] next_count;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty scan window, then ties, full use, reload and extremes
    alloc_req(0);
    set_count(CFG_W'(4));
    load_part(0, 10);
    load_part(1, 20);
    load_part(2, 10);
    load_part(3, 65535);
    alloc_req(10);
    alloc_req(10);
    alloc_req(10);
    alloc_req(0);
    alloc_req(0);
    load_part(2, 5);
    alloc_req(6);
    alloc_req(5);
    load_part(31, 65535);
    alloc_req(65535);
    set_count(CFG_W'(1));
    load_part(0, 65535);
    alloc_req(65535);

    while (sent < 1600) begin
      case ($urandom_range(0, 7))
        0:       next_count = CFG_W'(0);
        1:       next_count = CFG_W'(1);
        2:       next_count = CFG_W'(2);
        3:       next_count = CFG_W'(32);
        4:       next_count = CFG_W'(33);
        5:       next_count = CFG_W'(63);
        6:       next_count = CFG_W'($urandom_range(1, 32));
        default: next_count = CFG_W'($urandom_range(0, 63));
      endcase
      set_count(next_count);
      mode        = $urandom_range(0, 2);
      quiet_phase = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(40, 160);
      repeat (phase_len) random_cmd(mode);
    end
    start <= 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d commands left without a result",
                                        tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
